### rtl/core/jse_pkg.sv
// shared types and constants for the json string escaper
// no dependencies; imported by every module in rtl/core
package jse_pkg;

    typedef enum logic [1:0] {
        CMD_OPEN  = 2'd0,
        CMD_CHAR  = 2'd1,
        CMD_CLOSE = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    localparam int MAX_BYTES = 6;
    localparam int CNT_W     = 3;
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = 1;
    localparam int QCNT_W    = 2;

    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_U         = 8'h75;

    // one classified item: the bytes to send, first byte in slot 0
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [CNT_W-1:0]          count;
    } desc_t;

endpackage

### rtl/core/jse_front.sv
// front end: accepts command words, classifies them into byte descriptors
// depends on jse_pkg
module jse_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  logic [1:0]    command,
    input  logic [30:0]   code_point,
    input  logic          q_full,
    output logic          push,
    output jse_pkg::desc_t push_desc
);
    import jse_pkg::*;

    logic  vld_reg, vld_next;
    desc_t desc_reg;
    desc_t desc_cls;
    logic  accept;
    logic  [4:0][7:0] cb;
    logic  [7:0] esc;

    always_comb
    begin
        for (int j = 0; j < 5; j++)
        begin
            cb[j] = {2'b10, code_point[6*j +: 6]};
        end
    end

    always_comb
    begin
        desc_cls = '0;
        esc = 8'h00;
        case (cmd_t'(command))
            CMD_OPEN, CMD_CLOSE:
            begin
                desc_cls.bytes[0] = CH_QUOTE;
                desc_cls.count    = CNT_W'(1);
            end
            CMD_CHAR:
            begin
                if (code_point <= 31'h7F)
                begin
                    case (code_point[6:0])
                        7'h22: esc = CH_QUOTE;
                        7'h5C: esc = CH_BACKSLASH;
                        7'h09: esc = 8'h74;
                        7'h0C: esc = 8'h66;
                        7'h08: esc = 8'h62;
                        7'h0D: esc = 8'h72;
                        7'h0A: esc = 8'h6E;
                        default: esc = 8'h00;
                    endcase
                    if (code_point[6:0] == 7'h00)
                    begin
                        // nul goes out as \u0000
                        desc_cls.bytes[0] = CH_BACKSLASH;
                        desc_cls.bytes[1] = CH_U;
                        desc_cls.bytes[2] = CH_ZERO;
                        desc_cls.bytes[3] = CH_ZERO;
                        desc_cls.bytes[4] = CH_ZERO;
                        desc_cls.bytes[5] = CH_ZERO;
                        desc_cls.count    = CNT_W'(6);
                    end
                    else if (esc != 8'h00)
                    begin
                        desc_cls.bytes[0] = CH_BACKSLASH;
                        desc_cls.bytes[1] = esc;
                        desc_cls.count    = CNT_W'(2);
                    end
                    else
                    begin
                        desc_cls.bytes[0] = {1'b0, code_point[6:0]};
                        desc_cls.count    = CNT_W'(1);
                    end
                end
                else if (code_point <= 31'h7FF)
                begin
                    desc_cls.bytes[0] = {3'b110, code_point[10:6]};
                    desc_cls.bytes[1] = cb[0];
                    desc_cls.count    = CNT_W'(2);
                end
                else if (code_point <= 31'hFFFF)
                begin
                    desc_cls.bytes[0] = {4'b1110, code_point[15:12]};
                    desc_cls.bytes[1] = cb[1];
                    desc_cls.bytes[2] = cb[0];
                    desc_cls.count    = CNT_W'(3);
                end
                else if (code_point <= 31'h1FFFFF)
                begin
                    desc_cls.bytes[0] = {5'b11110, code_point[20:18]};
                    desc_cls.bytes[1] = cb[2];
                    desc_cls.bytes[2] = cb[1];
                    desc_cls.bytes[3] = cb[0];
                    desc_cls.count    = CNT_W'(4);
                end
                else if (code_point <= 31'h3FFFFFF)
                begin
                    desc_cls.bytes[0] = {6'b111110, code_point[25:24]};
                    desc_cls.bytes[1] = cb[3];
                    desc_cls.bytes[2] = cb[2];
                    desc_cls.bytes[3] = cb[1];
                    desc_cls.bytes[4] = cb[0];
                    desc_cls.count    = CNT_W'(5);
                end
                else
                begin
                    desc_cls.bytes[0] = {7'b1111110, code_point[30]};
                    desc_cls.bytes[1] = cb[4];
                    desc_cls.bytes[2] = cb[3];
                    desc_cls.bytes[3] = cb[2];
                    desc_cls.bytes[4] = cb[1];
                    desc_cls.bytes[5] = cb[0];
                    desc_cls.count    = CNT_W'(6);
                end
            end
            default:
            begin
                desc_cls = '0;
            end
        endcase
    end

    assign cmd_stall = vld_reg && q_full;
    assign accept    = cmd_valid && !cmd_stall;
    assign push      = vld_reg && !q_full;
    assign push_desc = desc_reg;

    // unused command code produces nothing, so it never takes the slot
    always_comb
    begin
        if (accept)
        begin
            vld_next = (cmd_t'(command) != CMD_NONE);
        end
        else
        begin
            vld_next = vld_reg && q_full;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            desc_reg <= desc_cls;
        end
    end

    // a held descriptor stays put until the queue takes it
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg && q_full |=> vld_reg && $stable(desc_reg))
        else $error("front slot lost while queue full");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg |-> (desc_reg.count != '0) && (desc_reg.count <= CNT_W'(MAX_BYTES)))
        else $error("descriptor with bad byte count");

endmodule

### rtl/core/jse_queue.sv
// small descriptor queue between front and back end
// depends on jse_pkg
module jse_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  jse_pkg::desc_t push_desc,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output jse_pkg::desc_t head
);
    import jse_pkg::*;

    desc_t             slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    assign full      = (cnt_reg == QCNT_W'(QDEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_desc;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full || pop)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("pop from empty queue");

endmodule

### rtl/core/jse_back.sv
// back end: walks descriptors byte by byte into the output register
// depends on jse_pkg
module jse_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_not_empty,
    input  jse_pkg::desc_t q_head,
    output logic           pop,
    output logic           byte_valid,
    input  logic           byte_stall,
    output logic [7:0]     out_byte,
    output logic           last_byte
);
    import jse_pkg::*;

    desc_t            cur_reg, cur_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             busy_reg, busy_next;
    logic             ovld_reg, ovld_next;
    logic [7:0]       obyte_reg, obyte_next;
    logic             olast_reg, olast_next;

    desc_t            src;
    logic [CNT_W-1:0] sel_idx;
    logic             load;
    logic             is_last;

    assign src     = busy_reg ? cur_reg : q_head;
    assign sel_idx = busy_reg ? idx_reg : '0;
    assign load    = (!ovld_reg || !byte_stall) && (busy_reg || q_not_empty);
    assign is_last = (sel_idx == src.count - CNT_W'(1));
    assign pop     = load && !busy_reg;

    always_comb
    begin
        cur_next   = cur_reg;
        idx_next   = idx_reg;
        busy_next  = busy_reg;
        obyte_next = obyte_reg;
        olast_next = olast_reg;
        ovld_next  = ovld_reg && byte_stall;
        if (load)
        begin
            ovld_next  = 1'b1;
            obyte_next = src.bytes[sel_idx];
            olast_next = is_last;
            if (!busy_reg)
            begin
                cur_next = q_head;
            end
            busy_next = !is_last;
            idx_next  = sel_idx + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            ovld_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            ovld_reg <= ovld_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        obyte_reg <= obyte_next;
        olast_reg <= olast_next;
    end

    assign byte_valid = ovld_reg;
    assign out_byte   = obyte_reg;
    assign last_byte  = olast_reg;

    // while an item is in progress its index is inside its byte count
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (idx_reg != '0) && (idx_reg < cur_reg.count))
        else $error("byte index out of range");

    // a new item starts only after the previous one sent its last byte
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !busy_reg)
        else $error("descriptor popped mid item");

endmodule

### rtl/core/json_string_escape_utf8.sv
// top level of the json string escaper with utf-8 encoding
// depends on jse_pkg, jse_front, jse_queue and jse_back
//
// Takes one command word per cycle while cmd_stall is low (open quote,
// encode one code point, close quote) and produces the bytes of a JSON
// string literal, one byte per output word, with last_byte set on the
// final byte of each command. Quote, backslash, tab, form feed,
// backspace, CR and LF come out as two-byte escapes, NUL as \u0000,
// other ASCII values raw, and larger code points as 2 to 6 byte UTF-8
// (no surrogate or range checking). Command code 3 is swallowed and
// produces nothing. The byte stage emits one byte per cycle while it has
// bytes and byte_stall is low, so a command takes one output word per
// byte, and multi-byte items can stall the command side even when the
// output keeps up. The first byte of a command passes the classify
// register, loaded at the accepting edge, then the queue slot, then the
// output register. A two-deep descriptor queue between
// classifier and byte stage absorbs short bursts of multi-byte items
// before cmd_stall rises.
module json_string_escape_utf8 (
    input  logic        clk,
    input  logic        rst_n,
    // command side
    input  logic        cmd_valid,
    output logic        cmd_stall,
    input  logic [1:0]  command,
    input  logic [30:0] code_point,
    // byte side
    output logic        byte_valid,
    input  logic        byte_stall,
    output logic [7:0]  out_byte,
    output logic        last_byte
);
    import jse_pkg::*;

    logic  push;
    desc_t push_desc;
    logic  q_full;
    logic  pop;
    logic  q_not_empty;
    desc_t q_head;

    // classify each command into a descriptor of ready-made bytes
    jse_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .command   (command),
        .code_point(code_point),
        .q_full    (q_full),
        .push      (push),
        .push_desc (push_desc)
    );

    // decouples classification from byte output
    jse_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    // one byte per cycle into the output register while byte_stall allows
    jse_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_not_empty(q_not_empty),
        .q_head     (q_head),
        .pop        (pop),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .out_byte   (out_byte),
        .last_byte  (last_byte)
    );

    // a stalled output word must not change under the consumer
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && byte_stall |=> byte_valid && $stable(out_byte)
            && $stable(last_byte))
        else $error("output word changed while stalled");

endmodule

### tb/sv/jse_check_pkg.sv
// expected-byte tracker for the json string escaper testbench
// depends on jse_pkg for the command codes and character constants
package jse_check_pkg;

    import jse_pkg::*;

    typedef struct {
        logic [7:0] value;
        logic       last;
    } out_word_t;

    class escaped_byte_tracker;

        out_word_t expected_bytes[$];
        int unsigned words_in;
        int unsigned ignored_words;
        int unsigned bytes_seen;
        int unsigned errors;

        function new();
            words_in      = 0;
            ignored_words = 0;
            bytes_seen    = 0;
            errors        = 0;
        endfunction

        // works out the bytes one accepted command word must produce
        function void note_command(cmd_t c, logic [30:0] cp);
            logic [7:0]  seq[$];
            logic [7:0]  esc;
            logic [7:0]  lead;
            logic [31:0] v;
            logic [31:0] part;
            int          tail_n;
            out_word_t   w;

            v = {1'b0, cp};
            words_in++;
            case (c)
                CMD_OPEN, CMD_CLOSE:
                    seq.push_back(CH_QUOTE);
                CMD_CHAR:
                    if (v <= 32'h7F) begin
                        esc = 8'h00;
                        case (v[6:0])
                            7'h22: esc = CH_QUOTE;
                            7'h5C: esc = CH_BACKSLASH;
                            7'h09: esc = "t";
                            7'h0C: esc = "f";
                            7'h08: esc = "b";
                            7'h0D: esc = "r";
                            7'h0A: esc = "n";
                            default: esc = 8'h00;
                        endcase
                        if (v[6:0] == 7'h00) begin
                            seq.push_back(CH_BACKSLASH);
                            seq.push_back(CH_U);
                            repeat (4) seq.push_back(CH_ZERO);
                        end
                        else if (esc != 8'h00) begin
                            seq.push_back(CH_BACKSLASH);
                            seq.push_back(esc);
                        end
                        else begin
                            seq.push_back({1'b0, v[6:0]});
                        end
                    end
                    else begin
                        if (v <= 32'h7FF) begin
                            tail_n = 1;
                            lead   = 8'hC0 | {3'b000, v[10:6]};
                        end
                        else if (v <= 32'hFFFF) begin
                            tail_n = 2;
                            lead   = 8'hE0 | {4'b0000, v[15:12]};
                        end
                        else if (v <= 32'h1FFFFF) begin
                            tail_n = 3;
                            lead   = 8'hF0 | {5'b00000, v[20:18]};
                        end
                        else if (v <= 32'h3FFFFFF) begin
                            tail_n = 4;
                            lead   = 8'hF8 | {6'b000000, v[25:24]};
                        end
                        else begin
                            tail_n = 5;
                            lead   = 8'hFC | {7'b0000000, v[30]};
                        end
                        seq.push_back(lead);
                        for (int k = tail_n - 1; k >= 0; k--) begin
                            part = v >> (6 * k);
                            seq.push_back({2'b10, part[5:0]});
                        end
                    end
                default:
                    ignored_words++;
            endcase
            foreach (seq[i]) begin
                w.value = seq[i];
                w.last  = (i == seq.size() - 1);
                expected_bytes.push_back(w);
            end
        endfunction

        // compares one accepted output word with the oldest expectation
        function void check_byte(logic [7:0] b, logic l);
            out_word_t w;

            bytes_seen++;
            if (expected_bytes.size() == 0) begin
                $error("out_byte: no byte expected, got %02h (last_byte %0b)", b, l);
                errors++;
                return;
            end
            w = expected_bytes.pop_front();
            if (b !== w.value) begin
                $error("out_byte: expected %02h, got %02h", w.value, b);
                errors++;
            end
            if (l !== w.last) begin
                $error("last_byte: expected %0b, got %0b", w.last, l);
                errors++;
            end
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

    endclass

endpackage

### tb/sv/json_string_escape_utf8_tb.sv
// top-level testbench for json_string_escape_utf8
// depends on jse_pkg and jse_check_pkg; drives commands, checks escaped bytes
module json_string_escape_utf8_tb;

    import jse_pkg::*;
    import jse_check_pkg::*;

    localparam int unsigned N_ITEMS    = 410;
    localparam int unsigned TAIL_ITEMS = 60;
    // no word moves on either side for this long means the block is hung
    localparam int unsigned IDLE_LIMIT = 2000;

    logic        clk;
    logic        rst_n;
    logic        cmd_valid;
    logic        cmd_stall;
    logic [1:0]  command;
    logic [30:0] code_point;
    logic        byte_valid;
    logic        byte_stall;
    logic [7:0]  out_byte;
    logic        last_byte;

    escaped_byte_tracker tracker;

    int unsigned items_sent;
    int unsigned idle_cycles;
    int unsigned stall_left;
    bit          quiet_tail;

    json_string_escape_utf8 uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .command    (command),
        .code_point (code_point),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .out_byte   (out_byte),
        .last_byte  (last_byte)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // monitor: both handshakes are sampled at the rising edge, inputs only
    // move at the falling edge so the sampled values are stable
    always @(posedge clk)
    begin : monitor
        bit moved;
        if (rst_n)
        begin
            moved = 1'b0;
            // note the command before checking, in case both land together
            if (cmd_valid && !cmd_stall)
            begin
                tracker.note_command(cmd_t'(command), code_point);
                moved = 1'b1;
            end
            if (byte_valid && !byte_stall)
            begin
                tracker.check_byte(out_byte, last_byte);
                moved = 1'b1;
            end
            if (moved)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // byte side backpressure: random stall bursts of random length,
    // switched off for the tail of the run
    initial
    begin
        byte_stall = 1'b0;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (quiet_tail)
            begin
                byte_stall = 1'b0;
            end
            else if (stall_left > 0)
            begin
                byte_stall = 1'b1;
                stall_left--;
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                byte_stall = 1'b1;
                stall_left = $urandom_range(0, 7);
            end
            else
            begin
                byte_stall = 1'b0;
            end
        end
    end

    // drives one command word; entered and left at a falling edge
    task automatic send_word(input cmd_t c, input logic [30:0] cp);
        int unsigned gap;
        if (!quiet_tail && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 8);
            cmd_valid  = 1'b0;
            code_point = 31'($urandom);
            repeat (gap) @(negedge clk);
        end
        cmd_valid  = 1'b1;
        command    = c;
        code_point = cp;
        do @(posedge clk); while (cmd_stall);
        @(negedge clk);
        if (c != CMD_NONE)
            items_sent++;
        if (items_sent >= N_ITEMS - TAIL_ITEMS)
            quiet_tail = 1'b1;
    endtask

    // code point spread over every escape class and every utf-8 length
    function automatic logic [30:0] rand_code_point();
        logic [30:0] cp;
        case ($urandom_range(0, 7))
            0:
            begin
                case ($urandom_range(0, 7))
                    0: cp = 31'h00;
                    1: cp = 31'h08;
                    2: cp = 31'h09;
                    3: cp = 31'h0A;
                    4: cp = 31'h0C;
                    5: cp = 31'h0D;
                    6: cp = 31'h22;
                    default: cp = 31'h5C;
                endcase
            end
            1, 2: cp = 31'($urandom_range(1, 32'h7F));
            3: cp = 31'($urandom_range(32'h80, 32'h7FF));
            4: cp = 31'($urandom_range(32'h800, 32'hFFFF));
            5: cp = 31'($urandom_range(32'h10000, 32'h1FFFFF));
            6: cp = 31'($urandom_range(32'h200000, 32'h3FFFFFF));
            default: cp = 31'($urandom_range(32'h4000000, 32'h7FFFFFFF));
        endcase
        return cp;
    endfunction

    initial
    begin
        int unsigned n_chars;
        tracker     = new();
        items_sent  = 0;
        idle_cycles = 0;
        quiet_tail  = 1'b0;
        rst_n       = 1'b0;
        cmd_valid   = 1'b0;
        command     = CMD_OPEN;
        code_point  = '0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: quotes with junk code points, every escape, nul,
        // raw control ascii 01 and 7f, each utf-8 length at its bounds,
        // a surrogate, bit 30 set and clear, and the unused command
        send_word(CMD_OPEN,  31'h7FFFFFFF);
        send_word(CMD_CHAR,  31'h00);
        send_word(CMD_CHAR,  31'h08);
        send_word(CMD_CHAR,  31'h09);
        send_word(CMD_CHAR,  31'h0A);
        send_word(CMD_CHAR,  31'h0C);
        send_word(CMD_CHAR,  31'h0D);
        send_word(CMD_CHAR,  31'h22);
        send_word(CMD_CHAR,  31'h5C);
        send_word(CMD_CHAR,  31'h01);
        send_word(CMD_CHAR,  31'h7F);
        send_word(CMD_CHAR,  31'h80);
        send_word(CMD_CHAR,  31'h7FF);
        send_word(CMD_CHAR,  31'h800);
        send_word(CMD_CHAR,  31'hD800);
        send_word(CMD_CHAR,  31'hFFFF);
        send_word(CMD_CHAR,  31'h10000);
        send_word(CMD_CHAR,  31'h1FFFFF);
        send_word(CMD_CHAR,  31'h200000);
        send_word(CMD_CHAR,  31'h3FFFFFF);
        send_word(CMD_CHAR,  31'h4000000);
        send_word(CMD_CHAR,  31'h40000000);
        send_word(CMD_CHAR,  31'h7FFFFFFF);
        send_word(CMD_NONE,  31'h2AAAAAAA);
        send_word(CMD_CLOSE, 31'h55555555);

        // hold the command side until the byte side has drained
        cmd_valid = 1'b0;
        while (tracker.pending() != 0) @(negedge clk);

        // random: mostly whole strings (open, chars, close), some stray words
        while (items_sent < N_ITEMS)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                send_word(CMD_OPEN, 31'($urandom));
                n_chars = $urandom_range(0, 12);
                repeat (n_chars) send_word(CMD_CHAR, rand_code_point());
                send_word(CMD_CLOSE, 31'($urandom));
            end
            else if ($urandom_range(0, 1) == 0)
            begin
                send_word(cmd_t'($urandom_range(0, 3)), 31'($urandom));
            end
            else
            begin
                send_word(CMD_CHAR, rand_code_point());
            end
        end

        cmd_valid = 1'b0;
        while (tracker.pending() != 0) @(negedge clk);
        // keep running so a stray extra byte would still show up
        repeat (20) @(negedge clk);

        $display("%0d command words accepted (%0d with the unused code), %0d bytes checked",
                 tracker.words_in, tracker.ignored_words, tracker.bytes_seen);
        $display("covered quotes, escapes, nul, raw ascii and 2 to 6 byte utf-8 under stalls");
        if (tracker.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### files.f
rtl/core/jse_pkg.sv
rtl/core/jse_front.sv
rtl/core/jse_queue.sv
rtl/core/jse_back.sv
rtl/core/json_string_escape_utf8.sv
tb/sv/jse_check_pkg.sv
tb/sv/json_string_escape_utf8_tb.sv
